// ----- rtl/core/ple_pkg.sv -----
// Shared types and codes for the positional list engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ple_pkg;

  localparam int DEFAULT_CAPACITY = 32;
  localparam int DATA_W = 32;

  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_APPEND = 3'd2;
  localparam logic [2:0] KIND_DELETE = 3'd3;
  localparam logic [2:0] KIND_RANGE  = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOPOS = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic [5:0]               count;
    logic                     last;
  } result_t;

endpackage

// ----- rtl/core/ple_ram.sv -----
// Element store of the positional list engine: one write port, one read
// port with registered read data. Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_ram
  import ple_pkg::*;
#(
  parameter int DEPTH = DEFAULT_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/ple_ctrl.sv -----
// Sequencer of the positional list engine: decodes an operation, walks the
// cursor one cell per step through the store, and hands out result beats.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_ctrl
  import ple_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        kind,
  input  logic [7:0]        position,
  input  logic [7:0]        end_position,
  input  logic [DATA_W-1:0] value,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [DATA_W-1:0] rd_data,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [DATA_W-1:0] wr_data
);

  localparam int PW = (CW > 8) ? CW : 8;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SH_RD = 8'b0000_0010,
    S_SH_WR = 8'b0000_0100,
    S_DL_RD = 8'b0000_1000,
    S_DL_WR = 8'b0001_0000,
    S_RG_RD = 8'b0010_0000,
    S_RG_EM = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     cursor, cursor_next;
  logic [CW-1:0]     slot, slot_next;
  logic [CW-1:0]     stop, stop_next;
  logic [DATA_W-1:0] val, val_next;
  logic [1:0]        status, status_next;

  logic [PW-1:0]     a_w, b_w, cnt_w;
  logic              a_bad, b_bad, full;
  logic [CW:0]       cursor_inc;

  assign a_w   = PW'(position);
  assign b_w   = PW'(end_position);
  assign cnt_w = PW'(count);
  assign a_bad = (a_w == '0) || (a_w > cnt_w);
  assign b_bad = (b_w == '0) || (b_w > cnt_w);
  assign full  = (count == CW'(CAPACITY));
  // shared step unit: cursor + 1, also used for the delete bound check
  assign cursor_inc = {1'b0, cursor} + 1'b1;

  always_comb begin
    state_next  = state;
    count_next  = count;
    cursor_next = cursor;
    slot_next   = slot;
    stop_next   = stop;
    val_next    = val;
    status_next = status;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    rd_en       = 1'b0;
    rd_addr     = cursor[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = cursor[AW-1:0];
    wr_data     = rd_data;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          val_next    = value;
          status_next = STATUS_OK;
          unique case (kind) inside
            KIND_READ: begin
              if (a_bad) begin
                status_next = STATUS_NOPOS;
                state_next  = S_EMIT;
              end else begin
                cursor_next = CW'(a_w);
                stop_next   = CW'(a_w);
                state_next  = S_RG_RD;
              end
            end
            KIND_INSERT, KIND_APPEND: begin
              if (full) begin
                status_next = STATUS_FULL;
                state_next  = S_EMIT;
              end else begin
                cursor_next = count;
                if (kind == KIND_APPEND || a_w > cnt_w) begin
                  slot_next = count;
                end else if (a_w == '0) begin
                  slot_next = '0;
                end else begin
                  slot_next = CW'(a_w - 1'b1);
                end
                state_next = S_SH_RD;
              end
            end
            KIND_DELETE: begin
              if (a_bad) begin
                status_next = STATUS_NOPOS;
                state_next  = S_EMIT;
              end else begin
                cursor_next = CW'(a_w - 1'b1);
                state_next  = S_DL_RD;
              end
            end
            KIND_RANGE: begin
              if (a_bad || b_bad) begin
                status_next = STATUS_NOPOS;
                state_next  = S_EMIT;
              end else begin
                cursor_next = CW'(a_w);
                stop_next   = (b_w < a_w) ? CW'(a_w) : CW'(b_w);
                state_next  = S_RG_RD;
              end
            end
            default: begin
              status_next = STATUS_NOPOS;
              state_next  = S_EMIT;
            end
          endcase
        end
      end

      // open a gap: move cells up one slot, top down to the insert slot
      S_SH_RD: begin
        if (cursor > slot) begin
          rd_en      = 1'b1;
          rd_addr    = AW'(cursor - 1'b1);
          state_next = S_SH_WR;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = slot[AW-1:0];
          wr_data    = val;
          count_next = count + 1'b1;
          state_next = S_EMIT;
        end
      end
      S_SH_WR: begin
        wr_en       = 1'b1;
        cursor_next = cursor - 1'b1;
        state_next  = S_SH_RD;
      end

      // close the gap: move cells down one slot
      S_DL_RD: begin
        if (cursor_inc < {1'b0, count}) begin
          rd_en      = 1'b1;
          rd_addr    = cursor_inc[AW-1:0];
          state_next = S_DL_WR;
        end else begin
          count_next = count - 1'b1;
          state_next = S_EMIT;
        end
      end
      S_DL_WR: begin
        wr_en       = 1'b1;
        cursor_next = cursor_inc[CW-1:0];
        state_next  = S_DL_RD;
      end

      // cursor holds a 1-based position; read data is held while waiting
      S_RG_RD: begin
        rd_en      = 1'b1;
        rd_addr    = AW'(cursor - 1'b1);
        state_next = S_RG_EM;
      end
      S_RG_EM: begin
        res_valid   = 1'b1;
        res.data    = rd_data;
        res.status  = STATUS_OK;
        res.count   = 6'(count);
        res.last    = (cursor == stop);
        if (res_ready) begin
          if (cursor == stop) begin
            state_next = S_IDLE;
          end else begin
            cursor_next = cursor_inc[CW-1:0];
            state_next  = S_RG_RD;
          end
        end
      end

      S_EMIT: begin
        res_valid  = 1'b1;
        res.data   = '0;
        res.status = status;
        res.count  = 6'(count);
        res.last   = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    cursor <= cursor_next;
    slot   <= slot_next;
    stop   <= stop_next;
    val    <= val_next;
    status <= status_next;
  end

endmodule

// ----- rtl/core/positional_list_engine.sv -----
// Top level of the positional list engine: sequencer, element store and
// output register. Depends on ple_pkg, ple_ram and ple_ctrl.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   kind, position, end_position, value
//   out      source     out_valid / out_ready data, status, count, last
//
// One item at a time; in_ready is high only while the sequencer is idle.
// A read or range read takes a read step and an emit step per element. Insert and delete
// move the cells behind the slot one at a time, each with a read step and then a write step
// through the single store port pair, before the emit step. Rejected items go straight to emit.
// A full output register stalls the sequencer in its emit step.
// rst (synchronous) empties the list; the store itself is not cleared.
`timescale 1ns / 1ps

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               kind,
  input  logic [7:0]               position,
  input  logic [7:0]               end_position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] data,
  output logic [1:0]               status,
  output logic [5:0]               count,
  output logic                     last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic              res_valid, res_ready;
  result_t           res, obuf;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [DATA_W-1:0] rd_data, wr_data;

  ple_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .position     (position),
    .end_position (end_position),
    .value        (value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  ple_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // output register: takes a new beat when empty or draining
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      obuf <= res;
    end
  end

  assign data   = obuf.data;
  assign status = obuf.status;
  assign count  = obuf.count;
  assign last   = obuf.last;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for positional_list_engine: drives list operations,
// mirrors the list in a queue and checks every result beat. Needs ple_pkg.
`timescale 1ns / 1ps

module testbench
  import ple_pkg::*;
();

  localparam int LIST_CAP      = DEFAULT_CAPACITY;
  localparam int LONG_STALL    = 300;
  localparam int SETTLE_CYCLES = 2 * LIST_CAP + 40;  // longest shift plus margin
  localparam int CYCLE_LIMIT   = 400000;

  // kinds the block rejects
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               kind = KIND_READ;
  logic [7:0]               position = 8'd0;
  logic [7:0]               end_position = 8'd0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] data;
  logic [1:0]               status;
  logic [5:0]               count;
  logic                     last;

  logic signed [DATA_W-1:0] list_vals[$];  // mirrored list contents
  result_t                  result_q[$];   // results still to come, oldest first
  result_t                  expected_beat;

  int error_count   = 0;
  int items_sent    = 0;
  int beats_checked = 0;
  int full_refusals = 0;
  int range_reads   = 0;
  int max_fill      = 0;
  int burst_left    = 0;
  int stall_order   = 0;
  int stall_seen    = 0;
  int stall_left    = 0;
  int ready_mode    = 0;
  int mode_left     = 0;
  int ready_tick    = 0;
  int cycle_count   = 0;

  positional_list_engine #(
    .CAPACITY(LIST_CAP)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .position    (position),
    .end_position(end_position),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data        (data),
    .status      (status),
    .count       (count),
    .last        (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void expect_beat(logic signed [DATA_W-1:0] d, logic [1:0] st,
                                      logic lst);
    result_t r;
    r.data   = d;
    r.status = st;
    r.count  = 6'(list_vals.size());
    r.last   = lst;
    result_q.push_back(r);
  endfunction

  function automatic void predict_list_op(logic [2:0] op, logic [7:0] a, logic [7:0] b,
                                          logic signed [DATA_W-1:0] v);
    int n;
    int slot;
    int stop;
    n = list_vals.size();
    case (op) inside
      KIND_READ: begin
        if (a < 1 || a > n) expect_beat('0, STATUS_NOPOS, 1'b1);
        else expect_beat(list_vals[a - 1], STATUS_OK, 1'b1);
      end
      KIND_INSERT, KIND_APPEND: begin
        if (n >= LIST_CAP) begin
          full_refusals++;
          expect_beat('0, STATUS_FULL, 1'b1);
        end else begin
          // past the end appends, position zero goes to the front
          if (op == KIND_APPEND || a > n) slot = n;
          else if (a == 0) slot = 0;
          else slot = a - 1;
          if (slot == n) list_vals.push_back(v);
          else list_vals.insert(slot, v);
          if (list_vals.size() > max_fill) max_fill = list_vals.size();
          expect_beat('0, STATUS_OK, 1'b1);
        end
      end
      KIND_DELETE: begin
        if (a < 1 || a > n) begin
          expect_beat('0, STATUS_NOPOS, 1'b1);
        end else begin
          list_vals.delete(a - 1);
          expect_beat('0, STATUS_OK, 1'b1);
        end
      end
      KIND_RANGE: begin
        range_reads++;
        if (a < 1 || b < 1 || a > n || b > n) begin
          expect_beat('0, STATUS_NOPOS, 1'b1);
        end else begin
          stop = (b < a) ? a : b;  // reversed range gives element a only
          for (int j = a; j <= stop; j++)
            expect_beat(list_vals[j - 1], STATUS_OK, j == stop);
        end
      end
      default: expect_beat('0, STATUS_NOPOS, 1'b1);
    endcase
  endfunction

  // ----------------------------------------------------------------- checking
  task automatic report_mismatch(string what);
    $display("ERROR @%0t: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        report_mismatch("result beat with no operation waiting for it");
      end else begin
        expected_beat = result_q.pop_front();
        if (data !== expected_beat.data)
          report_mismatch($sformatf("beat %0d: data %0d, expected %0d",
                                    beats_checked, data, expected_beat.data));
        if (status !== expected_beat.status)
          report_mismatch($sformatf("beat %0d: status %0d, expected %0d",
                                    beats_checked, status, expected_beat.status));
        if (count !== expected_beat.count)
          report_mismatch($sformatf("beat %0d: count %0d, expected %0d",
                                    beats_checked, count, expected_beat.count));
        if (last !== expected_beat.last)
          report_mismatch($sformatf("beat %0d: last %0b, expected %0b",
                                    beats_checked, last, expected_beat.last));
        beats_checked++;
      end
    end
  end

  // ----------------------------------------------------------------- receiver
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (stall_order != stall_seen) begin
      stall_seen <= stall_order;
      stall_left <= LONG_STALL;
      out_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(3);
        mode_left  <= $urandom_range(60, 10);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(1) == 0);
        2:       out_ready <= ($urandom_range(3) == 0);
        default: out_ready <= (ready_tick % 4) != 3;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected",
               cycle_count, result_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------------- sender
  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_item(logic [2:0] op, logic [7:0] a, logic [7:0] b,
                           logic signed [DATA_W-1:0] v);
    int gap;
    in_valid     <= 1'b1;
    kind         <= op;
    position     <= a;
    end_position <= b;
    value        <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_list_op(op, a, b, v);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(15);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) pause_sender(gap);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // mostly near the live range, sometimes zero or anywhere in 8 bits
  function automatic logic [7:0] pick_position(int n);
    case ($urandom_range(9))
      0:       return 8'($urandom_range(255));
      1:       return 8'd0;
      default: return 8'($urandom_range(n + 1, 1));
    endcase
  endfunction

  // -------------------------------------------------------------------- tests
  task automatic test_empty_list();
    send_item(KIND_READ, 8'd1, 8'd0, '0);
    send_item(KIND_READ, 8'd0, 8'd0, '0);
    send_item(KIND_DELETE, 8'd1, 8'd0, '0);
    send_item(KIND_RANGE, 8'd1, 8'd1, '0);
    send_item(KIND_UNUSED_LO, 8'd255, 8'd255, -32'sd1);
    send_item(3'(KIND_UNUSED_LO + 1), 8'd1, 8'd1, '0);
    send_item(KIND_UNUSED_HI, 8'd255, 8'd255, -32'sd1);
  endtask

  task automatic test_edge_values();
    send_item(KIND_APPEND, 8'd0, 8'd0, 32'sh7FFF_FFFF);
    send_item(KIND_APPEND, 8'd255, 8'd255, 32'sh8000_0000);
    send_item(KIND_INSERT, 8'd0, 8'd0, -32'sd1);          // front
    send_item(KIND_INSERT, 8'd255, 8'd0, '0);             // past the end
    send_item(KIND_INSERT, 8'd2, 8'd0, 32'sh5A5A_A5A5);   // middle
    send_item(KIND_READ, 8'd1, 8'd0, '0);
    send_item(KIND_READ, 8'd5, 8'd0, '0);
    send_item(KIND_READ, 8'd6, 8'd0, '0);
    send_item(KIND_RANGE, 8'd4, 8'd2, '0);                // reversed
    send_item(KIND_RANGE, 8'd1, 8'd5, '0);
    send_item(KIND_RANGE, 8'd2, 8'd255, '0);
    send_item(KIND_RANGE, 8'd0, 8'd3, '0);
    send_item(KIND_DELETE, 8'd3, 8'd0, '0);
    send_item(KIND_DELETE, 8'd0, 8'd0, '0);
    send_item(KIND_DELETE, 8'd255, 8'd0, '0);
    send_item(KIND_READ, 8'd3, 8'd0, '0);
  endtask

  task automatic test_random_mix(int n_items, int pct_grow, int pct_del);
    logic [2:0] op;
    logic [7:0] a;
    logic [7:0] b;
    int         n;
    int         r;
    repeat (n_items) begin
      n = list_vals.size();
      r = $urandom_range(99);
      if (r < pct_grow) op = ($urandom_range(1) == 0) ? KIND_INSERT : KIND_APPEND;
      else if (r < pct_grow + pct_del) op = KIND_DELETE;
      else if (r < pct_grow + pct_del + 12) op = KIND_READ;
      else if (r < 97) op = KIND_RANGE;
      else op = 3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      a = pick_position(n);
      b = pick_position(n);
      // keep most range reads legal and short
      if (op == KIND_RANGE && n > 0 && $urandom_range(3) != 0) begin
        a = 8'($urandom_range(n, 1));
        b = 8'(a + $urandom_range(6));
        if (b > n) b = 8'(n);
      end
      send_item(op, a, b, random_value());
    end
  endtask

  task automatic test_full_list();
    while (list_vals.size() < LIST_CAP) send_item(KIND_APPEND, 8'd0, 8'd0, random_value());
    send_item(KIND_APPEND, 8'd0, 8'd0, random_value());
    send_item(KIND_INSERT, 8'd1, 8'd0, random_value());
    send_item(KIND_INSERT, 8'd0, 8'd0, random_value());
    send_item(KIND_INSERT, 8'd255, 8'd0, random_value());
    send_item(KIND_RANGE, 8'd1, 8'(LIST_CAP), '0);
    send_item(KIND_READ, 8'(LIST_CAP), 8'd0, '0);
    send_item(KIND_READ, 8'(LIST_CAP + 1), 8'd0, '0);
  endtask

  // receiver holds off while a long range read and more beats queue up
  task automatic test_backpressure();
    if (list_vals.size() < 4) begin
      repeat (4) send_item(KIND_APPEND, 8'd0, 8'd0, random_value());
    end
    stall_order <= stall_order + 1;
    send_item(KIND_RANGE, 8'd1, 8'(list_vals.size()), '0);
    send_item(KIND_READ, 8'd1, 8'd0, '0);
    send_item(KIND_DELETE, 8'd1, 8'd0, '0);
    send_item(KIND_RANGE, 8'd2, 8'd4, '0);
    send_item(KIND_INSERT, 8'd3, 8'd0, random_value());
    send_item(KIND_READ, 8'd3, 8'd0, '0);
    send_item(KIND_DELETE, 8'(list_vals.size()), 8'd0, '0);
    send_item(KIND_RANGE, 8'd1, 8'(list_vals.size()), '0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_edge_values();
    wait_for_results();
    test_random_mix(50, 60, 10);
    test_full_list();
    test_backpressure();
    wait_for_results();
    test_random_mix(60, 35, 30);
    test_random_mix(40, 15, 60);
    test_random_mix(30, 45, 25);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d operations (%0d range reads, %0d inserts refused when full), "
             , items_sent, range_reads, full_refusals);
    $display("checked %0d result beats; list peaked at %0d entries, one %0d-cycle hold-off.",
             beats_checked, max_fill, LONG_STALL);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
